// ----- design/tpjq_pkg.sv -----
// Shared constants, codes and types for the two-priority job queue.
// Used by the controller, the datapath, the top level and the checker.
package tpjq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   localparam int ID_W        = 16;
   localparam int PAGE_W      = 16;
   localparam int PRIO_W      = 2;
   localparam int FUNC_W      = 3;
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 40;

   localparam logic [FUNC_W-1:0] FUNC_ADD      = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_CANCEL   = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_PROCESS  = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_LIST_FWD = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_LIST_REV = 3'd4;

   localparam logic [PRIO_W-1:0] PRIO_NORMAL = 2'd0;
   localparam logic [PRIO_W-1:0] PRIO_URGENT = 2'd1;

   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [PAGE_W-1:0] pages;
      logic              urgent;
   } slot_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SCAN,
      ST_EMPTY,
      ST_REMOVE,
      ST_INSERT,
      ST_LIST
   } state_type;

   typedef struct packed {
      logic latch_req;
      logic scan_clear;
      logic scan_tail;
      logic scan_inc;
      logic scan_dec;
      logic load_empty;
      logic load_slot;
      logic out_last;
      logic insert;
      logic remove;
   } dp_cmd_type;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic              prio_bad;
      logic              occ_zero;
      logic              occ_full;
      logic              scan_end;
      logic              id_match;
      logic              list_last;
      logic              out_busy;
   } dp_stat_type;

endpackage

// ----- design/tpjq_dpath.sv -----
// Datapath of the job queue: request register, slot array, scan pointer,
// occupancy count and result register. Depends on tpjq_pkg.
module tpjq_dpath (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [tpjq_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  logic [tpjq_pkg::FUNC_W-1:0]      req_tuser,
   input  tpjq_pkg::dp_cmd_type             cmd,
   output tpjq_pkg::dp_stat_type            stat,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [tpjq_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic [0:0]                       rsp_tuser,
   output logic                             rsp_tlast
);

   logic [tpjq_pkg::ID_W-1:0]   req_id_ff;
   logic [tpjq_pkg::PAGE_W-1:0] req_pages_ff;
   logic [tpjq_pkg::PRIO_W-1:0] req_prio_ff;
   logic [tpjq_pkg::FUNC_W-1:0] req_func_ff;

   logic [tpjq_pkg::CNT_W-1:0]  occ_ff, occ_in;
   logic [tpjq_pkg::CNT_W-1:0]  scan_ff, scan_in;

   tpjq_pkg::slot_type slots_ff   [tpjq_pkg::QUEUE_DEPTH];
   tpjq_pkg::slot_type slots_in   [tpjq_pkg::QUEUE_DEPTH];
   tpjq_pkg::slot_type prev_slot  [tpjq_pkg::QUEUE_DEPTH];
   tpjq_pkg::slot_type next_slot  [tpjq_pkg::QUEUE_DEPTH];
   tpjq_pkg::slot_type new_slot;
   tpjq_pkg::slot_type cur_slot;

   logic                             rsp_valid_ff, rsp_valid_in;
   logic [tpjq_pkg::RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                             rsp_has_ff, rsp_has_in;
   logic                             rsp_last_ff, rsp_last_in;

   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         req_id_ff    <= req_tdata[15:0];
         req_pages_ff <= req_tdata[31:16];
         req_prio_ff  <= req_tdata[33:32];
         req_func_ff  <= req_tuser;
      end
   end

   assign new_slot.id     = req_id_ff;
   assign new_slot.pages  = req_pages_ff;
   assign new_slot.urgent = (req_prio_ff == tpjq_pkg::PRIO_URGENT);
   assign cur_slot        = slots_ff[scan_ff[tpjq_pkg::IDX_W-1:0]];

   for (genvar i = 0; i < tpjq_pkg::QUEUE_DEPTH; i++) begin : g_slot
      localparam logic [tpjq_pkg::CNT_W-1:0] SLOT_IDX = tpjq_pkg::CNT_W'(i);

      if (i == 0) begin : g_first
         assign prev_slot[i] = new_slot;
      end else begin : g_prev
         assign prev_slot[i] = slots_ff[i-1];
      end

      if (i == tpjq_pkg::QUEUE_DEPTH - 1) begin : g_final
         assign next_slot[i] = slots_ff[i];
      end else begin : g_next
         assign next_slot[i] = slots_ff[i+1];
      end

      always_comb begin
         slots_in[i] = slots_ff[i];
         if (cmd.insert && new_slot.urgent) begin
            slots_in[i] = prev_slot[i];
         end else if (cmd.insert && (occ_ff == SLOT_IDX)) begin
            slots_in[i] = new_slot;
         end else if (cmd.remove && (SLOT_IDX >= scan_ff)) begin
            slots_in[i] = next_slot[i];
         end
      end

      always_ff @(posedge clock) begin
         slots_ff[i] <= slots_in[i];
      end
   end

   always_comb begin
      occ_in = occ_ff;
      if (cmd.insert) begin
         occ_in = occ_ff + 1'b1;
      end else if (cmd.remove) begin
         occ_in = occ_ff - 1'b1;
      end
   end

   always_comb begin
      scan_in = scan_ff;
      if (cmd.scan_clear) begin
         scan_in = '0;
      end else if (cmd.scan_tail) begin
         scan_in = occ_ff - 1'b1;
      end else if (cmd.scan_inc) begin
         scan_in = scan_ff + 1'b1;
      end else if (cmd.scan_dec) begin
         scan_in = scan_ff - 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_has_in   = rsp_has_ff;
      rsp_last_in  = rsp_last_ff;
      if (cmd.load_empty) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = '0;
         rsp_has_in   = 1'b0;
         rsp_last_in  = 1'b1;
      end else if (cmd.load_slot) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {7'd0, cur_slot.urgent, cur_slot.pages, cur_slot.id};
         rsp_has_in   = 1'b1;
         rsp_last_in  = cmd.out_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff     <= scan_in;
      rsp_data_ff <= rsp_data_in;
      rsp_has_ff  <= rsp_has_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign stat.func      = req_func_ff;
   assign stat.prio_bad  = (req_prio_ff > tpjq_pkg::PRIO_URGENT);
   assign stat.occ_zero  = (occ_ff == '0);
   assign stat.occ_full  = (occ_ff == tpjq_pkg::CNT_W'(tpjq_pkg::QUEUE_DEPTH));
   assign stat.scan_end  = (scan_ff == occ_ff);
   assign stat.id_match  = (cur_slot.id == req_id_ff);
   assign stat.list_last = (req_func_ff == tpjq_pkg::FUNC_LIST_REV) ? (scan_ff == '0)
                                                                     : (scan_ff == occ_ff - 1'b1);
   assign stat.out_busy  = rsp_valid_ff & ~rsp_tready;

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_has_ff;
   assign rsp_tlast    = rsp_last_ff;

endmodule

// ----- design/tpjq_ctrl.sv -----
// Controller state machine of the job queue: sequences decode, search,
// insert, remove and listing. Depends on tpjq_pkg.
module tpjq_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  tpjq_pkg::dp_stat_type stat,
   output tpjq_pkg::dp_cmd_type  cmd
);

   tpjq_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tpjq_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         tpjq_pkg::ST_IDLE: begin
            req_tready    = 1'b1;
            cmd.latch_req = req_tvalid;
            if (req_tvalid) begin
               state_in = tpjq_pkg::ST_DECODE;
            end
         end
         tpjq_pkg::ST_DECODE: begin
            priority case (stat.func)
               tpjq_pkg::FUNC_ADD: begin
                  if (stat.prio_bad) begin
                     state_in = tpjq_pkg::ST_EMPTY;
                  end else begin
                     cmd.scan_clear = 1'b1;
                     state_in       = tpjq_pkg::ST_SCAN;
                  end
               end
               tpjq_pkg::FUNC_CANCEL: begin
                  cmd.scan_clear = 1'b1;
                  state_in       = tpjq_pkg::ST_SCAN;
               end
               tpjq_pkg::FUNC_PROCESS: begin
                  cmd.scan_clear = 1'b1;
                  state_in = stat.occ_zero ? tpjq_pkg::ST_EMPTY : tpjq_pkg::ST_REMOVE;
               end
               tpjq_pkg::FUNC_LIST_FWD: begin
                  cmd.scan_clear = 1'b1;
                  state_in = stat.occ_zero ? tpjq_pkg::ST_EMPTY : tpjq_pkg::ST_LIST;
               end
               tpjq_pkg::FUNC_LIST_REV: begin
                  cmd.scan_tail = 1'b1;
                  state_in = stat.occ_zero ? tpjq_pkg::ST_EMPTY : tpjq_pkg::ST_LIST;
               end
               default: begin
                  state_in = tpjq_pkg::ST_EMPTY;
               end
            endcase
         end
         tpjq_pkg::ST_SCAN: begin
            if (stat.scan_end) begin
               if ((stat.func == tpjq_pkg::FUNC_ADD) && !stat.occ_full) begin
                  state_in = tpjq_pkg::ST_INSERT;
               end else begin
                  state_in = tpjq_pkg::ST_EMPTY;
               end
            end else if (stat.id_match) begin
               if (stat.func == tpjq_pkg::FUNC_ADD) begin
                  state_in = tpjq_pkg::ST_EMPTY;
               end else begin
                  state_in = tpjq_pkg::ST_REMOVE;
               end
            end else begin
               cmd.scan_inc = 1'b1;
            end
         end
         tpjq_pkg::ST_EMPTY: begin
            if (!stat.out_busy) begin
               cmd.load_empty = 1'b1;
               state_in       = tpjq_pkg::ST_IDLE;
            end
         end
         tpjq_pkg::ST_REMOVE: begin
            if (!stat.out_busy) begin
               cmd.load_slot = 1'b1;
               cmd.out_last  = 1'b1;
               cmd.remove    = 1'b1;
               state_in      = tpjq_pkg::ST_IDLE;
            end
         end
         tpjq_pkg::ST_INSERT: begin
            cmd.insert = 1'b1;
            state_in   = tpjq_pkg::ST_IDLE;
         end
         tpjq_pkg::ST_LIST: begin
            if (!stat.out_busy) begin
               cmd.load_slot = 1'b1;
               cmd.out_last  = stat.list_last;
               if (stat.list_last) begin
                  state_in = tpjq_pkg::ST_IDLE;
               end else if (stat.func == tpjq_pkg::FUNC_LIST_REV) begin
                  cmd.scan_dec = 1'b1;
               end else begin
                  cmd.scan_inc = 1'b1;
               end
            end
         end
         default: begin
            state_in = tpjq_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ----- design/two_priority_job_queue_top.sv -----
// Each item is latched in idle and decoded; add and cancel then search the queue, one compare per cycle.
// A cancel, duplicate or full add stops its search at the match or at the end and gives its result;
// process, list and other items go straight to their result, lists then one result per cycle
// unless the result output stalls. One item is handled at a time.
// Reset (synchronous, active high) empties the queue and the result register.
// Top level of the job queue: joins the controller and the datapath; uses tpjq_pkg.
module two_priority_job_queue_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // job_id [15:0], page_count [31:16], priority_req [33:32], zero [39:34]
   input  logic [tpjq_pkg::REQ_TDATA_W-1:0] req_tdata,
   // func [2:0]
   input  logic [tpjq_pkg::FUNC_W-1:0]      req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // out_job_id [15:0], out_page_count [31:16], out_urgent [32], zero [39:33]
   output logic [tpjq_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // has_job [0]
   output logic [0:0]                       rsp_tuser,
   output logic                             rsp_tlast
);

   tpjq_pkg::dp_cmd_type  cmd;
   tpjq_pkg::dp_stat_type stat;

   tpjq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   tpjq_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ----- design/tpjq_checker.sv -----
// Port-level checks for the job queue top level, bound to every instance.
// Depends on tpjq_pkg and two_priority_job_queue_top.
module tpjq_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic [tpjq_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic [0:0]                       rsp_tuser,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic                             rsp_tlast
);

   a_reset_clears_rsp: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("item accepted while previous item still in work");

   a_empty_line_form: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tlast && (rsp_tdata == '0))
      else $error("empty line carries data or lacks last");

   a_non_last_has_job: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tuser[0])
      else $error("non-final result without a job");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result changed");

endmodule

bind two_priority_job_queue_top tpjq_checker u_tpjq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tlast  (rsp_tlast)
);
